### design/assert_macros.svh
// Assertion macros shared by the scanner modules.
// Each expects signals named clock and reset in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as trig.
`define ASSERT_NOW(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after trig.
`define ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

### design/lmpwm_pkg.sv
// Shared types, codes and sizes for the LED matrix PWM row scanner.
// No dependencies; every other file of the block but assert_macros.svh imports it.
package lmpwm_pkg;

   // Default geometry, handed down from the top level
   localparam int ROWS_DEFAULT        = 8;
   localparam int ROW_ENTRIES_DEFAULT = 16;
   localparam int BUFFERS             = 2;

   // Fixed field widths of the request and response words
   localparam int OPERATION_W = 2;
   localparam int ROW_W       = 3;
   localparam int COLUMN_W    = 4;
   localparam int LEVEL_W     = 8;
   localparam int MASK_BITS   = 16;
   localparam int SLICE_W     = 4;

   // Depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Request operation codes
   localparam logic [OPERATION_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OPERATION_W-1:0] OP_FLIP  = 2'd1;
   localparam logic [OPERATION_W-1:0] OP_TICK  = 2'd2;

   // Command kinds that survive classification
   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_FLIP  = 2'd1,
      CMD_TICK  = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic [ROW_W-1:0]        row;
      logic [COLUMN_W-1:0]     column;
      logic [LEVEL_W-1:0]      level;
   } cmd_type;

   // Handshake between the queue and the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

endpackage

### design/lmpwm_if.sv
// Channel interfaces of the scanner: request, response and register write.
// Depends on lmpwm_pkg for the field widths.
interface lmpwm_req_if;
   import lmpwm_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [OPERATION_W-1:0] operation;
   logic [ROW_W-1:0]       pixel_row;
   logic [COLUMN_W-1:0]    pixel_column;
   logic [LEVEL_W-1:0]     pixel_level;
   modport source (output valid, operation, pixel_row, pixel_column, pixel_level,
                   input ready);
   modport sink   (input valid, operation, pixel_row, pixel_column, pixel_level,
                   output ready);
endinterface

interface lmpwm_rsp_if;
   import lmpwm_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [ROW_W-1:0]     row_address;
   logic [MASK_BITS-1:0] row_bits;
   logic                 last_row;
   modport source (output valid, row_address, row_bits, last_row, input ready);
   modport sink   (input valid, row_address, row_bits, last_row, output ready);
endinterface

interface lmpwm_csr_if;
   logic valid;
   logic ready;
   logic data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

### design/lmpwm_front.sv
// Front end: holds the scan enable, accepts request words and drops the ones
// that have no effect. Depends on lmpwm_pkg and lmpwm_if.
module lmpwm_front #(
   parameter int ROWS        = lmpwm_pkg::ROWS_DEFAULT,
   parameter int ROW_ENTRIES = lmpwm_pkg::ROW_ENTRIES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   lmpwm_req_if.sink           req_chan,
   lmpwm_csr_if.sink           csr_chan,
   input  logic                q_ready,
   output logic                q_push,
   output lmpwm_pkg::cmd_type  q_cmd
);
   import lmpwm_pkg::*;

   logic scan_on_ff, scan_on_in;
   logic row_ok, column_ok, keep;

   // Take register writes at any time
   assign csr_chan.ready = 1'b1;
   always_comb begin
      scan_on_in = scan_on_ff;
      if (csr_chan.valid) begin
         scan_on_in = csr_chan.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_on_ff <= 1'b0;
      end else begin
         scan_on_ff <= scan_on_in;
      end
   end

   // Classify the word: keep in-range writes, flips and enabled ticks
   assign row_ok    = {1'b0, req_chan.pixel_row} < (ROW_W + 1)'(ROWS);
   assign column_ok = {3'b000, req_chan.pixel_column} < (COLUMN_W + 3)'(ROW_ENTRIES);

   always_comb begin
      keep         = 1'b0;
      q_cmd.kind   = CMD_WRITE;
      q_cmd.row    = req_chan.pixel_row;
      q_cmd.column = req_chan.pixel_column;
      q_cmd.level  = req_chan.pixel_level;
      case (req_chan.operation)
         OP_WRITE: begin
            keep       = row_ok && column_ok;
            q_cmd.kind = CMD_WRITE;
         end
         OP_FLIP: begin
            keep       = 1'b1;
            q_cmd.kind = CMD_FLIP;
         end
         OP_TICK: begin
            keep       = scan_on_ff;
            q_cmd.kind = CMD_TICK;
         end
         default: begin
            keep       = 1'b0;
            q_cmd.kind = CMD_WRITE;
         end
      endcase
   end

   assign req_chan.ready = q_ready;
   assign q_push         = req_chan.valid && q_ready && keep;

endmodule

### design/lmpwm_queue.sv
// Short command queue between the front and back ends.
// Depends on lmpwm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lmpwm_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  lmpwm_pkg::cmd_type        push_cmd,
   output logic                      push_ready,
   input  logic                      pop,
   output lmpwm_pkg::queue_head_type head
);
   import lmpwm_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign head.valid = count_ff != '0;
   assign head.cmd   = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH), "queue count over depth")
   `ASSERT_NOW(a_no_overflow, count_ff == CNT_W'(QUEUE_DEPTH), !push, "push into full queue")
   `ASSERT_NEXT(a_count_step, push && !pop, count_ff == $past(count_ff) + CNT_W'(1), "count slip")

endmodule

### design/lmpwm_back.sv
// Back end: frame store, buffer select, PWM slice and the row scan sequencer
// feeding the response register. Depends on lmpwm_pkg, lmpwm_if, assert_macros.svh.
`include "assert_macros.svh"
module lmpwm_back #(
   parameter int ROWS        = lmpwm_pkg::ROWS_DEFAULT,
   parameter int ROW_ENTRIES = lmpwm_pkg::ROW_ENTRIES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lmpwm_pkg::queue_head_type head,
   output logic                      pop,
   lmpwm_rsp_if.source               rsp_chan
);
   import lmpwm_pkg::*;

   localparam int DEPTH  = BUFFERS * ROWS;
   localparam int AW     = $clog2(DEPTH);
   localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int WORD_W = ROW_ENTRIES * LEVEL_W;
   localparam int MASK_N = (ROW_ENTRIES < MASK_BITS) ? ROW_ENTRIES : MASK_BITS;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_LOAD = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic                 front_ff, front_in;
   logic [SLICE_W-1:0]   slice_ff, slice_in;
   logic [RW-1:0]        row_ff, row_in;
   logic [DEPTH-1:0]     row_valid_ff, row_valid_in;

   logic [WORD_W-1:0]    mem [DEPTH];
   logic [WORD_W-1:0]    rd_word_ff;
   logic                 rd_valid_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]     row_address_ff;
   logic [MASK_BITS-1:0] row_bits_ff;
   logic                 last_row_ff;

   logic                 wr_en, rd_en, load_ok, load, row_last;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [WORD_W-1:0]    wr_data;
   logic [ROW_ENTRIES-1:0] wr_byte_en;
   logic [MASK_BITS-1:0] mask;
   logic [LEVEL_W-1:0]   threshold, level;

   // Address decode: upper half of the store holds buffer one
   assign wr_addr = (front_ff ? AW'(0) : AW'(ROWS)) + AW'(head.cmd.row);
   assign rd_addr = (front_ff ? AW'(ROWS) : AW'(0)) + AW'(row_ff);

   assign pop      = head.valid && (state_ff == ST_IDLE);
   assign wr_en    = pop && (head.cmd.kind == CMD_WRITE);
   assign rd_en    = state_ff == ST_READ;
   assign load_ok  = !rsp_valid_ff || rsp_chan.ready;
   assign load     = (state_ff == ST_LOAD) && load_ok;
   assign row_last = row_ff == RW'(ROWS - 1);

   // Build the write word; a never-written row is filled with zeros around the entry
   always_comb begin
      for (int e = 0; e < ROW_ENTRIES; e++) begin
         wr_data[e*LEVEL_W +: LEVEL_W] =
            ((COLUMN_W + 3)'(e) == {3'b000, head.cmd.column}) ? head.cmd.level : '0;
         wr_byte_en[e] = !row_valid_ff[wr_addr] ||
            ((COLUMN_W + 3)'(e) == {3'b000, head.cmd.column});
      end
   end

   // Frame store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int e = 0; e < ROW_ENTRIES; e++) begin
            if (wr_byte_en[e]) begin
               mem[wr_addr][e*LEVEL_W +: LEVEL_W] <= wr_data[e*LEVEL_W +: LEVEL_W];
            end
         end
      end
      if (rd_en) begin
         rd_word_ff  <= mem[rd_addr];
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   // Compare each entry of the fetched row against the slice threshold
   assign threshold = {slice_ff, 4'b0000};
   always_comb begin
      mask  = '0;
      level = '0;
      for (int i = 0; i < MASK_N; i++) begin
         level   = rd_valid_ff ? rd_word_ff[i*LEVEL_W +: LEVEL_W] : '0;
         mask[i] = level > threshold;
      end
   end

   // Sequence commands and the row scan
   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      slice_in     = slice_ff;
      row_in       = row_ff;
      row_valid_in = row_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (wr_en) begin
         row_valid_in[wr_addr] = 1'b1;
      end
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               case (head.cmd.kind)
                  CMD_FLIP: begin
                     front_in = !front_ff;
                  end
                  CMD_TICK: begin
                     slice_in = slice_ff + SLICE_W'(1);
                     row_in   = '0;
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (load_ok) begin
               rsp_valid_in = 1'b1;
               if (row_last) begin
                  state_in = ST_IDLE;
               end else begin
                  row_in   = row_ff + RW'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= 1'b0;
         slice_ff     <= '0;
         row_ff       <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         slice_ff     <= slice_in;
         row_ff       <= row_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the response word until taken
   always_ff @(posedge clock) begin
      if (load) begin
         row_address_ff <= ROW_W'(row_ff);
         row_bits_ff    <= mask;
         last_row_ff    <= row_last;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.row_address = row_address_ff;
   assign rsp_chan.row_bits    = row_bits_ff;
   assign rsp_chan.last_row    = last_row_ff;

   `ASSERT_NOW(a_last_addr, rsp_valid_ff && last_row_ff, row_address_ff == ROW_W'(ROWS - 1), "last row address")
   `ASSERT_NEXT(a_scan_end, load && row_last, state_ff == ST_IDLE && rsp_valid_ff && last_row_ff, "scan end")
   `ASSERT_NEXT(a_slice_step, pop && head.cmd.kind == CMD_TICK, slice_ff == $past(slice_ff) + SLICE_W'(1), "slice step")

endmodule

### design/led_matrix_pwm_row_scanner_core.sv
// LED matrix PWM row scanner. Writes and flips are done in the back end while it idles;
// a tick scans every row, fetching it from the frame store (READ), then comparing it and
// loading the response register (LOAD); the back end takes no command until the scan ends.
// Requests are taken while the 4-word command queue has room.
// Reset is synchronous, active high: clears control, buffer select, slice and the row
// valid bits, so the frame store reads as zero at once without a clearing pass.
module led_matrix_pwm_row_scanner_core #(
   parameter int ROWS        = lmpwm_pkg::ROWS_DEFAULT,
   parameter int ROW_ENTRIES = lmpwm_pkg::ROW_ENTRIES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   lmpwm_req_if.sink    req_chan,
   lmpwm_rsp_if.source  rsp_chan,
   lmpwm_csr_if.sink    csr_chan
);
   import lmpwm_pkg::*;

   logic           q_ready, q_push, q_pop;
   cmd_type        q_cmd;
   queue_head_type q_head;

   // Accept and classify request words
   lmpwm_front #(.ROWS(ROWS), .ROW_ENTRIES(ROW_ENTRIES)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .csr_chan (csr_chan),
      .q_ready  (q_ready),
      .q_push   (q_push),
      .q_cmd    (q_cmd)
   );

   // Decouple front and back
   lmpwm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_cmd),
      .push_ready (q_ready),
      .pop        (q_pop),
      .head       (q_head)
   );

   // Carry out commands and scan rows
   lmpwm_back #(.ROWS(ROWS), .ROW_ENTRIES(ROW_ENTRIES)) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (q_head),
      .pop      (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

### tb/sv/led_matrix_pwm_row_scanner_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the LED matrix PWM row scanner core.
// Depends on lmpwm_pkg and the channel interfaces in lmpwm_if; predicts every row word.
module led_matrix_pwm_row_scanner_core_tb;
   import lmpwm_pkg::*;

   localparam int SCAN_ROWS    = ROWS_DEFAULT;
   localparam int SCAN_ENTRIES = ROW_ENTRIES_DEFAULT;
   localparam int SLICE_STEP   = 16;
   localparam int GAP_MAX      = 16;
   // Queued writes and flips may still be in flight once the last row word is in
   localparam int IDLE_SETTLE  = (QUEUE_DEPTH + 1) * 2 * ROWS_DEFAULT + 8;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int HOLD_CYCLES  = 300;

   // Operation code that the block ignores
   localparam logic [OPERATION_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [ROW_W-1:0]     row_address;
      logic [MASK_BITS-1:0] row_bits;
      logic                 last_row;
   } scan_row_type;

   logic clock = 1'b0;
   logic reset;

   lmpwm_req_if req_chan ();
   lmpwm_rsp_if rsp_chan ();
   lmpwm_csr_if csr_chan ();

   led_matrix_pwm_row_scanner_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Predicted state of the scanner
   logic [LEVEL_W-1:0] frame_levels [BUFFERS][SCAN_ROWS][SCAN_ENTRIES];
   logic               shown_buffer;
   logic [SLICE_W-1:0] pwm_slice;
   logic               display_on;

   scan_row_type rows_due [$];
   int        error_count    = 0;
   int        words_accepted = 0;
   int        cycle_count    = 0;
   int        hold_cycles    = 0;
   logic      gaps_on        = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a run that hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("led_matrix_pwm_row_scanner_core_tb: errors");
         $finish;
      end
   end

   // Apply one accepted word to the predicted state; queue the rows a tick scans
   function automatic void scan_frame(input logic [OPERATION_W-1:0] op,
                                      input logic [ROW_W-1:0] row,
                                      input logic [COLUMN_W-1:0] column,
                                      input logic [LEVEL_W-1:0] level);
      logic         back;
      int           threshold;
      scan_row_type row_word;
      back = ~shown_buffer;
      case (op)
         OP_WRITE: begin
            frame_levels[back][row][column] = level;
         end
         OP_FLIP: begin
            shown_buffer = back;
         end
         OP_TICK: begin
            if (display_on) begin
               pwm_slice = pwm_slice + 1'b1;
               threshold = int'(pwm_slice) * SLICE_STEP;
               for (int r = 0; r < SCAN_ROWS; r++) begin
                  row_word.row_address = ROW_W'(r);
                  row_word.row_bits    = '0;
                  row_word.last_row    = (r == SCAN_ROWS - 1);
                  for (int i = 0; i < SCAN_ENTRIES && i < MASK_BITS; i++) begin
                     if (int'(frame_levels[shown_buffer][r][i]) > threshold)
                        row_word.row_bits[i] = 1'b1;
                  end
                  rows_due.push_back(row_word);
               end
            end
         end
         default: ;
      endcase
   endfunction

   // Level picker that favours the ends of the PWM range and the slice thresholds
   function automatic logic [LEVEL_W-1:0] pick_level();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'd240;
         3:       return 8'd241;
         4:       return 8'd1;
         default: return LEVEL_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Offer one request word, after a random gap when gaps are on, and hold it until taken
   task automatic send_word(input logic [OPERATION_W-1:0] op,
                            input logic [ROW_W-1:0] row,
                            input logic [COLUMN_W-1:0] column,
                            input logic [LEVEL_W-1:0] level);
      int gap;
      gap = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.operation    <= op;
      req_chan.pixel_row    <= row;
      req_chan.pixel_column <= column;
      req_chan.pixel_level  <= level;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      scan_frame(op, row, column, level);
      if (op != OP_UNUSED)
         words_accepted++;
   endtask

   task automatic send_random_word(input logic [OPERATION_W-1:0] op);
      send_word(op, ROW_W'($urandom_range(0, SCAN_ROWS - 1)),
                COLUMN_W'($urandom_range(0, SCAN_ENTRIES - 1)), pick_level());
   endtask

   // Drop valid, drain expected rows, then let queued words settle
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (rows_due.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic write_scan_on(input logic value);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      display_on = value;
      csr_chan.valid <= 1'b0;
   endtask

   // Blank display after reset, ignored code, then first lit tick
   task automatic test_blank_display();
      send_word(OP_TICK, 3'd0, 4'd0, 8'd0);
      send_word(OP_UNUSED, 3'd7, 4'd15, 8'd255);
      send_word(OP_WRITE, 3'd7, 4'd15, 8'd255);
      send_word(OP_FLIP, 3'd0, 4'd0, 8'd0);
      send_word(OP_TICK, 3'd7, 4'd15, 8'd255);
      wait_idle();
      write_scan_on(1'b1);
      send_word(OP_TICK, 3'd0, 4'd0, 8'd0);
   endtask

   // Levels around the slice thresholds, swept through every slice but slice 1, and the wrap
   task automatic test_pwm_levels();
      send_word(OP_WRITE, 3'd0, 4'd0, 8'd0);
      send_word(OP_WRITE, 3'd0, 4'd1, 8'd1);
      send_word(OP_WRITE, 3'd0, 4'd5, 8'd17);
      send_word(OP_WRITE, 3'd0, 4'd9, 8'd240);
      send_word(OP_WRITE, 3'd0, 4'd14, 8'd241);
      send_word(OP_WRITE, 3'd4, 4'd0, 8'd128);
      send_word(OP_FLIP, 3'd0, 4'd0, 8'd0);
      repeat (15) send_word(OP_TICK, 3'd0, 4'd0, 8'd0);
   endtask

   // Mostly well-formed frames: fill the back buffer, flip, scan; some noise between
   task automatic test_random_frames(input int word_count);
      int target;
      target = words_accepted + word_count;
      while (words_accepted < target) begin
         repeat ($urandom_range(1, 10)) send_random_word(OP_WRITE);
         if ($urandom_range(0, 9) != 0)
            send_random_word(OP_FLIP);
         repeat ($urandom_range(0, 3)) send_random_word(OP_TICK);
         case ($urandom_range(0, 9))
            0:       send_random_word(OP_UNUSED);
            1:       send_random_word(OP_FLIP);
            default: ;
         endcase
      end
   endtask

   // Hold the row words off while ticks keep coming so the request side stalls
   task automatic test_result_backpressure();
      gaps_on = 1'b0;
      hold_cycles = HOLD_CYCLES;
      repeat (24) send_random_word(OP_TICK);
      wait_idle();
      gaps_on = 1'b1;
   endtask

   // Receiver: random stalls per word, plus the long hold when asked
   initial begin : rsp_receiver
      int stall;
      rsp_chan.ready <= 1'b0;
      forever begin
         stall = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
         if (hold_cycles > 0 || stall > 0) begin
            rsp_chan.ready <= 1'b0;
            while (hold_cycles > 0) begin
               @(posedge clock);
               hold_cycles--;
            end
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid && hold_cycles == 0) @(posedge clock);
      end
   end

   // Compare each row word taken with the oldest prediction
   always @(posedge clock) begin : row_checker
      scan_row_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (rows_due.size() == 0) begin
            error_count++;
            $error("unexpected row word: row_address %0d row_bits %h",
                   rsp_chan.row_address, rsp_chan.row_bits);
         end else begin
            want = rows_due.pop_front();
            if (rsp_chan.row_address !== want.row_address) begin
               error_count++;
               $error("row_address: expected %0d, got %0d", want.row_address,
                      rsp_chan.row_address);
            end
            if (rsp_chan.row_bits !== want.row_bits) begin
               error_count++;
               $error("row_bits: expected %h, got %h", want.row_bits, rsp_chan.row_bits);
            end
            if (rsp_chan.last_row !== want.last_row) begin
               error_count++;
               $error("last_row: expected %0d, got %0d", want.last_row, rsp_chan.last_row);
            end
         end
      end
   end

   initial begin
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.operation    <= OP_WRITE;
      req_chan.pixel_row    <= '0;
      req_chan.pixel_column <= '0;
      req_chan.pixel_level  <= '0;
      csr_chan.valid        <= 1'b0;
      csr_chan.data         <= 1'b0;
      for (int b = 0; b < BUFFERS; b++)
         for (int r = 0; r < SCAN_ROWS; r++)
            for (int i = 0; i < SCAN_ENTRIES; i++)
               frame_levels[b][r][i] = '0;
      shown_buffer = 1'b0;
      pwm_slice    = '0;
      display_on   = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_blank_display();
      test_pwm_levels();
      test_random_frames(60);

      // Blanked display: writes and flips still land
      wait_idle();
      write_scan_on(1'b0);
      test_random_frames(40);
      wait_idle();
      write_scan_on(1'b1);

      // Back-to-back stretch with no idling on either side
      gaps_on = 1'b0;
      test_random_frames(50);
      gaps_on = 1'b1;

      test_result_backpressure();
      test_random_frames(60);

      wait_idle();
      if (error_count == 0) begin
         $display("led_matrix_pwm_row_scanner_core_tb: clean");
      end else begin
         $display("led_matrix_pwm_row_scanner_core_tb: errors");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+design
design/lmpwm_pkg.sv
design/lmpwm_if.sv
design/lmpwm_front.sv
design/lmpwm_queue.sv
design/lmpwm_back.sv
design/led_matrix_pwm_row_scanner_core.sv
tb/sv/led_matrix_pwm_row_scanner_core_tb.sv
